>>> rtl/core/wtrs_pkg.sv
// Package for the weighted table route selector.
// Holds the sizes, item types, operation codes and the remainder unit's interface.
// No dependencies.
package wtrs_pkg;

	localparam int NUM_VNETS = 4;
	localparam int NUM_LINKS = 8;
	localparam int NUM_DESTS = 64;

	localparam int OP_W = 2;
	localparam int VNET_W = 2;
	localparam int LINK_W = 3;
	localparam int DEST_W = 64;
	localparam int WEIGHT_W = 8;
	localparam int RAND_W = 16;
	localparam int COUNT_W = 4;
	localparam int ORDER_W = 4;

	localparam int MASK_DEPTH = NUM_VNETS * NUM_LINKS;
	localparam int MASK_AW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
	localparam int LINK_IDX_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
	localparam int LCNT_W = $clog2(NUM_LINKS + 1);

	localparam logic [DEST_W-1:0] DEST_KEEP =
		(NUM_DESTS >= DEST_W) ? {DEST_W{1'b1}} : ((DEST_W'(1) << NUM_DESTS) - DEST_W'(1));

	localparam int MOD_BITS = 2;
	localparam int MOD_STEPS = RAND_W / MOD_BITS;
	localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_MASK = 2'd1;
	localparam logic [OP_W-1:0] OP_WR_WEIGHT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [VNET_W-1:0] vnet;
		logic [LINK_W-1:0] link;
		logic [DEST_W-1:0] dest_mask;
		logic [WEIGHT_W-1:0] weight;
		logic [RAND_W-1:0] rand_value;
	} req_t;

	typedef struct packed {
		logic [LINK_W-1:0] out_link;
		logic no_route;
		logic [COUNT_W-1:0] candidate_count;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic [RAND_W-1:0] dividend;
		logic [COUNT_W-1:0] divisor;
	} mod_cmd_t;

	typedef struct packed {
		logic done;
		logic [COUNT_W-1:0] rem;
	} mod_rsp_t;

endpackage

>>> rtl/core/wtrs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module wtrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/wtrs_mod.sv
// Iterative remainder unit: dividend modulo a small divisor, two bits per cycle.
// Depends on wtrs_pkg.
module wtrs_mod (
	input logic clk,
	input logic arst_n,
	input wtrs_pkg::mod_cmd_t cmd,
	output wtrs_pkg::mod_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [wtrs_pkg::MOD_CNT_W-1:0] step_q;
	logic [wtrs_pkg::RAND_W-1:0] dvd_q;
	logic [wtrs_pkg::COUNT_W-1:0] div_q;
	logic [wtrs_pkg::COUNT_W-1:0] rem_q;
	logic [wtrs_pkg::COUNT_W-1:0] rem_next;

	always_comb begin
		logic [wtrs_pkg::COUNT_W:0] r;
		rem_next = rem_q;
		for (int i = 0; i < wtrs_pkg::MOD_BITS; i++) begin
			r = {rem_next, dvd_q[wtrs_pkg::RAND_W-1-i]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
			rem_next = r[wtrs_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == wtrs_pkg::MOD_CNT_W'(wtrs_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			div_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << wtrs_pkg::MOD_BITS;
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem = rem_q;

endmodule

>>> rtl/core/weighted_table_route_select_unit.sv
// Top level of the weighted table route selector.
// Depends on wtrs_pkg, wtrs_ram and wtrs_mod.
//
// Usage: request items arrive on req_valid/req_ready. A mask write stores a
// destination mask for one virtual network and link, a weight write stores one
// link weight; neither of the two returns an item. A lookup returns one
// item on rsp_valid/rsp_ready with the chosen link, a no-route flag and the
// number of least-weight candidates. cfg_valid/cfg_data write the ordered
// virtual network mask and are always accepted; write it only while idle.
// A lookup reads the eight masks of its virtual network from the mask RAM,
// one per cycle through the registered read port, then selects the
// least-weight candidates in ST_EVAL; for an unordered virtual network with
// at least one candidate it then runs the remainder unit, and last it loads
// the response register in ST_PICK. The next item is accepted after that load.
// Reset clears all masks through per-entry valid bits, all weights and the
// configuration, at once. When the receiver stalls, the finished response
// waits in its register and the block holds before loading the next one.
module weighted_table_route_select_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wtrs_pkg::ORDER_W-1:0] cfg_data,
	input logic req_valid,
	output logic req_ready,
	input wtrs_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output wtrs_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_MOD,
		ST_PICK
	} state_t;

	state_t state_q;

	logic [wtrs_pkg::ORDER_W-1:0] ordered_q;
	logic [wtrs_pkg::WEIGHT_W-1:0] wt_q [wtrs_pkg::NUM_LINKS];
	logic [wtrs_pkg::MASK_DEPTH-1:0] mval_q;

	logic [wtrs_pkg::VNET_W-1:0] vnet_q;
	logic vnet_ok_q;
	logic [wtrs_pkg::DEST_W-1:0] dest_q;
	logic [wtrs_pkg::RAND_W-1:0] rand_q;
	logic [wtrs_pkg::LCNT_W-1:0] cnt_q;
	logic [wtrs_pkg::WEIGHT_W:0] min_q;
	logic [wtrs_pkg::NUM_LINKS-1:0] hit_q;
	logic [wtrs_pkg::NUM_LINKS-1:0] cand_q;
	logic [wtrs_pkg::COUNT_W-1:0] count_q;
	logic [wtrs_pkg::COUNT_W-1:0] pick_q;

	logic rd_vld_s1;
	logic [wtrs_pkg::LINK_IDX_W-1:0] rd_link_s1;
	logic [wtrs_pkg::MASK_AW-1:0] rd_addr_s1;

	logic rsp_valid_q;
	wtrs_pkg::rsp_t rsp_q;

	logic req_fire;
	logic mask_we;
	logic [wtrs_pkg::MASK_AW-1:0] mask_waddr;
	logic mask_re;
	logic [wtrs_pkg::MASK_AW-1:0] mask_raddr;
	logic [wtrs_pkg::DEST_W-1:0] mask_rdata;
	logic hit_c;
	logic [wtrs_pkg::NUM_LINKS-1:0] cand_c;
	logic [wtrs_pkg::COUNT_W-1:0] count_c;
	logic ordered_c;
	logic rsp_load;
	wtrs_pkg::mod_cmd_t mod_cmd;
	wtrs_pkg::mod_rsp_t mod_rsp;

	function automatic logic [wtrs_pkg::LINK_W-1:0] select_nth(
		input logic [wtrs_pkg::NUM_LINKS-1:0] cand,
		input logic [wtrs_pkg::COUNT_W-1:0] nth
	);
		logic [wtrs_pkg::COUNT_W-1:0] seen;
		logic found;
		logic [wtrs_pkg::LINK_W-1:0] sel;
		seen = '0;
		found = 1'b0;
		sel = '0;
		for (int l = 0; l < wtrs_pkg::NUM_LINKS; l++) begin
			if (cand[l] && !found) begin
				if (seen == nth) begin
					sel = wtrs_pkg::LINK_W'(l);
					found = 1'b1;
				end
				seen = seen + 1'b1;
			end
		end
		return sel;
	endfunction

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire = req_valid && req_ready;

	assign mask_we = req_fire && (req.op == wtrs_pkg::OP_WR_MASK)
		&& (int'(req.vnet) < wtrs_pkg::NUM_VNETS) && (int'(req.link) < wtrs_pkg::NUM_LINKS);
	assign mask_waddr = wtrs_pkg::MASK_AW'(int'(req.vnet) * wtrs_pkg::NUM_LINKS
		+ int'(req.link));
	assign mask_re = (state_q == ST_SCAN) && (int'(cnt_q) < wtrs_pkg::NUM_LINKS);
	assign mask_raddr = wtrs_pkg::MASK_AW'(int'(vnet_q) * wtrs_pkg::NUM_LINKS
		+ int'(cnt_q[wtrs_pkg::LINK_IDX_W-1:0]));

	wtrs_ram #(
		.WIDTH(wtrs_pkg::DEST_W),
		.DEPTH(wtrs_pkg::MASK_DEPTH)
	) u_mask_ram (
		.clk(clk),
		.we(mask_we),
		.waddr(mask_waddr),
		.wdata(req.dest_mask & wtrs_pkg::DEST_KEEP),
		.re(mask_re),
		.raddr(mask_raddr),
		.rdata(mask_rdata)
	);

	assign hit_c = vnet_ok_q && mval_q[rd_addr_s1] && ((mask_rdata & dest_q) != '0);

	always_comb begin
		count_c = '0;
		for (int l = 0; l < wtrs_pkg::NUM_LINKS; l++) begin
			cand_c[l] = hit_q[l] && ({1'b0, wt_q[l]} == min_q);
			count_c = count_c + wtrs_pkg::COUNT_W'(cand_c[l]);
		end
	end

	assign ordered_c = ordered_q[vnet_q];
	assign rsp_load = (state_q == ST_PICK) && (!rsp_valid_q || rsp_ready);

	assign mod_cmd.start = (state_q == ST_EVAL) && (count_c != '0) && !ordered_c;
	assign mod_cmd.dividend = rand_q;
	assign mod_cmd.divisor = count_c;

	wtrs_mod u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(mod_cmd),
		.rsp(mod_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q <= '0;
			mval_q <= '0;
			for (int l = 0; l < wtrs_pkg::NUM_LINKS; l++) begin
				wt_q[l] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				ordered_q <= cfg_data;
			end
			if (mask_we) begin
				mval_q[mask_waddr] <= 1'b1;
			end
			if (req_fire && (req.op == wtrs_pkg::OP_WR_WEIGHT)
				&& (int'(req.link) < wtrs_pkg::NUM_LINKS)) begin
				wt_q[req.link[wtrs_pkg::LINK_IDX_W-1:0]] <= req.weight;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			rd_vld_s1 <= mask_re;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.op == wtrs_pkg::OP_LOOKUP)) begin
						cnt_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mask_re) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_vld_s1
						&& (int'(rd_link_s1) == wtrs_pkg::NUM_LINKS - 1)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (mod_cmd.start) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_PICK;
					end
				end
				ST_MOD: begin
					if (mod_rsp.done) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_link_s1 <= cnt_q[wtrs_pkg::LINK_IDX_W-1:0];
		rd_addr_s1 <= mask_raddr;
		if (req_fire && (req.op == wtrs_pkg::OP_LOOKUP)) begin
			vnet_q <= req.vnet;
			vnet_ok_q <= (int'(req.vnet) < wtrs_pkg::NUM_VNETS);
			dest_q <= req.dest_mask & wtrs_pkg::DEST_KEEP;
			rand_q <= req.rand_value;
			min_q <= (wtrs_pkg::WEIGHT_W + 1)'(1 << wtrs_pkg::WEIGHT_W);
			hit_q <= '0;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			hit_q[rd_link_s1] <= hit_c;
			if (hit_c && ({1'b0, wt_q[rd_link_s1]} < min_q)) begin
				min_q <= {1'b0, wt_q[rd_link_s1]};
			end
		end
		if (state_q == ST_EVAL) begin
			cand_q <= cand_c;
			count_q <= count_c;
			pick_q <= '0;
		end
		if ((state_q == ST_MOD) && mod_rsp.done) begin
			pick_q <= mod_rsp.rem;
		end
		if (rsp_load) begin
			rsp_q.no_route <= (count_q == '0);
			rsp_q.candidate_count <= count_q;
			rsp_q.out_link <= (count_q == '0) ? '0 : select_nth(cand_q, pick_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_no_route_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.no_route |-> rsp.candidate_count == '0 && rsp.out_link == '0)
		else $error("no-route item carries a candidate count or link");

	a_route_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.no_route |-> rsp.candidate_count != '0
			&& int'(rsp.candidate_count) <= wtrs_pkg::NUM_LINKS)
		else $error("routed item has an impossible candidate count");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> state_q == ST_MOD)
		else $error("remainder finished outside its wait state");

	a_pick_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PICK && count_q != '0 |-> pick_q < count_q)
		else $error("candidate pick is not below the candidate count");

endmodule
